// ===== design/tmcw_pkg.sv =====
// tmcw_pkg: shared types and constants of the text-mode console writer
// beat structs, command codes, character codes and default screen geometry
// no dependencies
package tmcw_pkg;

  // default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // tab stops every eight columns
  localparam int TAB_STOP = 8;

  // input kinds
  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_SET   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  // control characters
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;

  // attribute and blank cell after reset
  localparam logic [7:0]  RESET_ATTR  = 8'h07;
  localparam logic [15:0] RESET_BLANK = {RESET_ATTR, BLANK_CHAR};

  // input beat
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  char_code;
    logic [6:0]  new_column;
    logic [4:0]  new_row;
    logic [10:0] cell_index;
  } in_item_t;

  // output beat
  typedef struct packed {
    logic [15:0] cell_value;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_position;
    logic        scrolled;
  } out_item_t;

  // classified operations handed from front to back
  typedef enum logic [3:0] {
    OP_PRINT,
    OP_NEWLINE,
    OP_RETURN,
    OP_TAB,
    OP_BACKSPACE,
    OP_SET,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_t;

  // queued command
  typedef struct packed {
    op_t         op;
    logic [7:0]  ch;
    logic [6:0]  col;
    logic [4:0]  row;
    logic [10:0] cidx;
  } cmd_t;

endpackage

// ===== design/tmcw_front.sv =====
// tmcw_front: accepts input beats and classifies them into commands
// saturates cursor coordinates and range-checks cell reads
// depends on tmcw_pkg
module tmcw_front import tmcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     init_busy,
  input  logic     push_ready,
  output logic     push_valid,
  output cmd_t     push_cmd
);

  localparam int NCELLS = COLUMNS * ROWS;

  // take a beat only when the queue has room and the store is cleared
  assign in_ready   = push_ready && !init_busy;
  assign push_valid = in_valid && in_ready;

  // classify the beat
  always_comb begin
    push_cmd.ch   = in_data.char_code;
    push_cmd.cidx = in_data.cell_index;
    push_cmd.col  = (32'(in_data.new_column) >= COLUMNS) ? 7'(COLUMNS - 1)
                                                         : in_data.new_column;
    push_cmd.row  = (32'(in_data.new_row) >= ROWS) ? 5'(ROWS - 1) : in_data.new_row;
    case (in_data.kind)
      KIND_PUT: begin
        case (in_data.char_code)
          CH_NEWLINE:   push_cmd.op = OP_NEWLINE;
          CH_RETURN:    push_cmd.op = OP_RETURN;
          CH_TAB:       push_cmd.op = OP_TAB;
          CH_BACKSPACE: push_cmd.op = OP_BACKSPACE;
          default:      push_cmd.op = OP_PRINT;
        endcase
      end
      KIND_SET:   push_cmd.op = OP_SET;
      KIND_CLEAR: push_cmd.op = OP_CLEAR;
      default: begin
        // reads outside the screen return zero and touch nothing
        push_cmd.op = (32'(in_data.cell_index) < NCELLS) ? OP_READ : OP_NOP;
      end
    endcase
  end

endmodule

// ===== design/tmcw_queue.sv =====
// tmcw_queue: short command queue between front and back
// lets the front keep accepting while the back scrolls or clears
// depends on tmcw_pkg
module tmcw_queue import tmcw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_cmd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (32'(count) < QUEUE_DEPTH);
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== design/tmcw_back.sv =====
// tmcw_back: executes commands against the screen store and cursor
// holds the store, the attribute register, the sweep sequencer and the output register
// depends on tmcw_pkg
module tmcw_back import tmcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       init_busy,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  localparam int NCELLS = COLUMNS * ROWS;
  localparam int AW     = $clog2(NCELLS);
  localparam int LW     = AW + 1;
  localparam int COL_W  = $clog2(COLUMNS + TAB_STOP);
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int CNT_W  = $clog2(NCELLS + 1);

  typedef enum logic [3:0] {
    ST_INIT   = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SWEEP  = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  // screen store, rows kept as a ring starting at top_base
  logic [15:0]      mem [NCELLS];
  logic [15:0]      rdata;

  state_t           state, state_next;
  logic [COL_W-1:0] col, col_next;
  logic [ROW_W-1:0] row, row_next;
  logic [AW-1:0]    top_base, top_next;
  logic [AW-1:0]    sweep_addr, sweep_addr_next;
  logic [CNT_W-1:0] sweep_cnt, sweep_cnt_next;
  logic [15:0]      sweep_data, sweep_data_next;
  logic [7:0]       attr;
  logic             scrolled, scrolled_next;
  logic             cell_ok, cell_ok_next;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [15:0]      wdata;
  logic             rd_en;
  logic [AW-1:0]    raddr;
  logic [LW-1:0]    lin_c;
  logic [LW-1:0]    lin_w;
  logic [LW-1:0]    wsum;
  logic [LW-1:0]    rsum;
  logic [AW-1:0]    waddr_exec;
  logic [COL_W-1:0] col_inc;
  logic [COL_W-1:0] col_tab;
  logic             do_nl;
  logic             out_load;
  logic [15:0]      blank;

  assign init_busy = (state == ST_INIT);
  assign blank     = {attr, BLANK_CHAR};

  // linear cursor position and physical cell addresses
  assign lin_c      = LW'(row) * LW'(COLUMNS) + LW'(col);
  assign lin_w      = (q_cmd.op == OP_BACKSPACE) ? lin_c - LW'(1) : lin_c;
  assign wsum       = lin_w + LW'(top_base);
  assign waddr_exec = (wsum >= LW'(NCELLS)) ? AW'(wsum - LW'(NCELLS)) : AW'(wsum);
  assign rsum       = LW'(q_cmd.cidx) + LW'(top_base);
  assign raddr      = (rsum >= LW'(NCELLS)) ? AW'(rsum - LW'(NCELLS)) : AW'(rsum);
  assign col_inc    = col + COL_W'(1);
  assign col_tab    = (col + COL_W'(TAB_STOP)) & ~COL_W'(TAB_STOP - 1);

  // sequencer
  always_comb begin
    state_next      = state;
    col_next        = col;
    row_next        = row;
    top_next        = top_base;
    sweep_addr_next = sweep_addr;
    sweep_cnt_next  = sweep_cnt;
    sweep_data_next = sweep_data;
    scrolled_next   = scrolled;
    cell_ok_next    = cell_ok;
    we              = 1'b0;
    waddr           = waddr_exec;
    wdata           = blank;
    rd_en           = 1'b0;
    q_pop           = 1'b0;
    do_nl           = 1'b0;
    out_load        = 1'b0;
    case (state)
      ST_INIT: begin
        we              = 1'b1;
        waddr           = sweep_addr;
        wdata           = RESET_BLANK;
        sweep_addr_next = sweep_addr + AW'(1);
        sweep_cnt_next  = sweep_cnt - CNT_W'(1);
        if (sweep_cnt == CNT_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          scrolled_next = 1'b0;
          cell_ok_next  = 1'b0;
          state_next    = ST_RESULT;
          case (q_cmd.op)
            OP_PRINT: begin
              we    = 1'b1;
              wdata = {attr, q_cmd.ch};
              if (32'(col_inc) >= COLUMNS) begin
                do_nl = 1'b1;
              end else begin
                col_next = col_inc;
              end
            end
            OP_NEWLINE: do_nl = 1'b1;
            OP_RETURN:  col_next = '0;
            OP_TAB: begin
              if (32'(col_tab) >= COLUMNS) begin
                do_nl = 1'b1;
              end else begin
                col_next = col_tab;
              end
            end
            OP_BACKSPACE: begin
              if (col != '0) begin
                col_next = col - COL_W'(1);
                we       = 1'b1;
              end
            end
            OP_SET: begin
              col_next = COL_W'(q_cmd.col);
              row_next = ROW_W'(q_cmd.row);
            end
            OP_CLEAR: begin
              col_next        = '0;
              row_next        = '0;
              sweep_addr_next = '0;
              sweep_cnt_next  = CNT_W'(NCELLS);
              sweep_data_next = blank;
              state_next      = ST_SWEEP;
            end
            OP_READ: begin
              rd_en        = 1'b1;
              cell_ok_next = 1'b1;
            end
            default: ;
          endcase
          // move to the next line, scrolling from the last row
          if (do_nl) begin
            col_next = '0;
            if (row == ROW_W'(ROWS - 1)) begin
              scrolled_next   = 1'b1;
              top_next        = (32'(top_base) + COLUMNS == NCELLS) ? '0
                                                                    : top_base + AW'(COLUMNS);
              sweep_addr_next = top_base;
              sweep_cnt_next  = CNT_W'(COLUMNS);
              sweep_data_next = blank;
              state_next      = ST_SWEEP;
            end else begin
              row_next = row + ROW_W'(1);
            end
          end
        end
      end
      ST_SWEEP: begin
        we              = 1'b1;
        waddr           = sweep_addr;
        wdata           = sweep_data;
        sweep_addr_next = sweep_addr + AW'(1);
        sweep_cnt_next  = sweep_cnt - CNT_W'(1);
        if (sweep_cnt == CNT_W'(1)) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        out_load = !out_valid || out_ready;
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

  // screen store port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      col        <= '0;
      row        <= '0;
      top_base   <= '0;
      sweep_addr <= '0;
      sweep_cnt  <= CNT_W'(NCELLS);
      scrolled   <= 1'b0;
      cell_ok    <= 1'b0;
      attr       <= RESET_ATTR;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      col        <= col_next;
      row        <= row_next;
      top_base   <= top_next;
      sweep_addr <= sweep_addr_next;
      sweep_cnt  <= sweep_cnt_next;
      scrolled   <= scrolled_next;
      cell_ok    <= cell_ok_next;
      if (cfg_we) begin
        attr <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sweep fill value
  always_ff @(posedge clk) begin
    sweep_data <= sweep_data_next;
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.cell_value      <= cell_ok ? rdata : 16'h0000;
      out_data.cursor_column   <= 7'(col);
      out_data.cursor_row      <= 5'(row);
      out_data.cursor_position <= 11'(lin_c);
      out_data.scrolled        <= scrolled;
    end
  end

endmodule

// ===== design/text_mode_console_writer.sv =====
// text_mode_console_writer: top level of the text-mode console engine
// connects the classifying front, the command queue and the executing back
// depends on tmcw_pkg, tmcw_front, tmcw_queue, tmcw_back
//
// The console keeps COLUMNS x ROWS character cells in a single-port-write store and a
// cursor; each accepted beat gives exactly one result beat with the cell read, the
// cursor and its linear position. After reset the store is cleared one cell per cycle,
// so no beat is taken until every cell has been cleared. Printable characters,
// controls, cursor moves and reads pass through the idle and result states of the
// back end; a scroll adds a sweep that blanks the new bottom row and a clear-screen
// adds a sweep over every cell, both written cell by cell through the one write port
// of the store. Scrolling only rotates a row offset, so the rest of the screen is not
// copied. A two-entry command queue lets the front keep accepting while the back is
// busy, and an output register holds a finished result while the next command runs.
module text_mode_console_writer import tmcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic init_busy;
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // accept and classify
  tmcw_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .init_busy (init_busy),
    .push_ready(push_ready),
    .push_valid(push_valid),
    .push_cmd  (push_cmd)
  );

  // command queue
  tmcw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_cmd   (q_cmd)
  );

  // execute against the screen store
  tmcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .init_busy(init_busy),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== design/tmcw_checker.sv =====
// tmcw_checker: port-level assertions for the text-mode console writer
// bound to the top level; depends on tmcw_pkg
module tmcw_checker import tmcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // no beat is taken just after reset, while the store is being cleared
  assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input taken during reset clearing pass");

  // cursor stays on the screen
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(out_data.cursor_column) < COLUMNS
               && 32'(out_data.cursor_row) < ROWS)
    else $error("cursor off screen");

  // linear position agrees with column and row
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.cursor_position ==
      11'(32'(out_data.cursor_row) * COLUMNS + 32'(out_data.cursor_column)))
    else $error("cursor position mismatch");

  // a scroll always leaves the cursor at the start of the last row
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.scrolled |-> out_data.cursor_column == 7'd0
      && 32'(out_data.cursor_row) == ROWS - 1)
    else $error("scroll left cursor out of place");

endmodule

bind text_mode_console_writer tmcw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tmcw_checker (.*);

// ===== test/tb_text_mode_console_writer.sv =====
// tb_text_mode_console_writer: self-checking testbench of the text-mode console writer
// keeps a shadow screen and cursor, drives commands with random idling and compares every beat
// depends on tmcw_pkg and text_mode_console_writer
module tb_text_mode_console_writer;
  timeunit 1ns;
  timeprecision 1ps;
  import tmcw_pkg::*;

  localparam int N_COLS         = DEF_COLUMNS;
  localparam int N_ROWS         = DEF_ROWS;
  localparam int N_CELLS        = N_COLS * N_ROWS;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 200;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_we;
  logic [7:0] cfg_wdata;

  // shadow copy of the console
  logic [15:0] shadow_cells [N_CELLS];
  int          shadow_col;
  int          shadow_row;
  logic [7:0]  shadow_attr;

  // cursor reports waiting for their beat
  out_item_t   reports_q [$];
  out_item_t   report_seen;
  int          fails = 0;
  int          stuck_cycles = 0;

  // idling control shared with the receiver
  bit          no_idle = 1'b0;
  int          rx_hold_len = 0;

  text_mode_console_writer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // fill the shadow screen with blanks in the current attribute
  function automatic void blank_screen();
    for (int i = 0; i < N_CELLS; i++) shadow_cells[i] = {shadow_attr, BLANK_CHAR};
  endfunction

  // column 0 of the next row, scrolling up one row past the bottom
  function automatic bit advance_line();
    shadow_col = 0;
    shadow_row++;
    if (shadow_row >= N_ROWS) begin
      for (int i = 0; i < N_CELLS - N_COLS; i++) shadow_cells[i] = shadow_cells[i + N_COLS];
      for (int i = N_CELLS - N_COLS; i < N_CELLS; i++) shadow_cells[i] = {shadow_attr, BLANK_CHAR};
      shadow_row = N_ROWS - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // apply one command to the shadow console and build its cursor report
  function automatic out_item_t console_apply(input in_item_t cmd);
    out_item_t rep;
    rep = '0;
    case (cmd.kind)
      KIND_PUT: begin
        case (cmd.char_code)
          CH_NEWLINE: rep.scrolled = advance_line();
          CH_RETURN: shadow_col = 0;
          CH_TAB: begin
            shadow_col = (shadow_col + TAB_STOP) & ~(TAB_STOP - 1);
            if (shadow_col >= N_COLS) rep.scrolled = advance_line();
          end
          CH_BACKSPACE: begin
            if (shadow_col > 0) begin
              shadow_col--;
              shadow_cells[shadow_row * N_COLS + shadow_col] = {shadow_attr, BLANK_CHAR};
            end
          end
          default: begin
            shadow_cells[shadow_row * N_COLS + shadow_col] = {shadow_attr, cmd.char_code};
            shadow_col++;
            if (shadow_col >= N_COLS) rep.scrolled = advance_line();
          end
        endcase
      end
      KIND_SET: begin
        shadow_col = (cmd.new_column >= N_COLS) ? N_COLS - 1 : int'(cmd.new_column);
        shadow_row = (cmd.new_row >= N_ROWS) ? N_ROWS - 1 : int'(cmd.new_row);
      end
      KIND_CLEAR: begin
        blank_screen();
        shadow_col = 0;
        shadow_row = 0;
      end
      default: begin
        if (cmd.cell_index < N_CELLS) rep.cell_value = shadow_cells[cmd.cell_index];
      end
    endcase
    rep.cursor_column   = shadow_col[6:0];
    rep.cursor_row      = shadow_row[4:0];
    rep.cursor_position = 11'(shadow_row * N_COLS + shadow_col);
    return rep;
  endfunction

  // command with random content in the fields that its kind ignores
  function automatic in_item_t make_cmd(input logic [1:0] kind, input int ch = -1,
                                        input int col = -1, input int row = -1,
                                        input int idx = -1);
    in_item_t cmd;
    cmd.kind       = kind;
    cmd.char_code  = (ch  < 0) ? 8'($urandom)  : 8'(ch);
    cmd.new_column = (col < 0) ? 7'($urandom)  : 7'(col);
    cmd.new_row    = (row < 0) ? 5'($urandom)  : 5'(row);
    cmd.cell_index = (idx < 0) ? 11'($urandom) : 11'(idx);
    return cmd;
  endfunction

  // random terminal traffic: mostly text, some controls, cursor moves often near the bottom, reads and rare clears
  function automatic in_item_t random_cmd();
    int pick;
    int idx;
    pick = $urandom_range(999);
    if (pick < 5) return make_cmd(KIND_CLEAR);
    if (pick < 560) begin
      if ($urandom_range(9) < 8) return make_cmd(KIND_PUT, $urandom_range(8'h7E, 8'h20));
      return make_cmd(KIND_PUT, $urandom_range(255));
    end
    if (pick < 650) begin
      case ($urandom_range(3))
        0: return make_cmd(KIND_PUT, CH_NEWLINE);
        1: return make_cmd(KIND_PUT, CH_RETURN);
        2: return make_cmd(KIND_PUT, CH_TAB);
        default: return make_cmd(KIND_PUT, CH_BACKSPACE);
      endcase
    end
    if (pick < 730) begin
      pick = $urandom_range(9);
      return make_cmd(KIND_SET, -1,
                      ($urandom_range(4) == 0) ? $urandom_range(127) : $urandom_range(N_COLS - 1),
                      (pick < 4) ? $urandom_range(N_ROWS - 1, N_ROWS - 2) :
                      (pick == 4) ? $urandom_range(31) : $urandom_range(N_ROWS - 1));
    end
    // reads mostly just behind the cursor, where the text was written
    pick = $urandom_range(99);
    if (pick < 60) begin
      idx = shadow_row * N_COLS + shadow_col - $urandom_range(90);
      if (idx < 0) idx = $urandom_range(N_CELLS - 1);
    end else if (pick < 85) begin
      idx = $urandom_range(N_CELLS - 1);
    end else begin
      idx = $urandom_range(2047);
    end
    return make_cmd(KIND_READ, -1, -1, -1, idx);
  endfunction

  // offer one command beat, with random idle cycles ahead of it
  task automatic send_cmd(input in_item_t cmd);
    if (!no_idle) begin
      while ($urandom_range(99) < 33) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (!in_ready);
    reports_q.push_back(console_apply(cmd));
  endtask

  // stop offering and wait for every report to come back
  task automatic drain_reports();
    in_valid <= 1'b0;
    while (reports_q.size() != 0) @(posedge clk);
  endtask

  // attribute write while nothing is in flight
  task automatic set_attr(input logic [7:0] attr);
    drain_reports();
    cfg_we    <= 1'b1;
    cfg_wdata <= attr;
    @(posedge clk);
    cfg_we      <= 1'b0;
    shadow_attr = attr;
  endtask

  task automatic random_traffic(input int count);
    for (int i = 0; i < count; i++) send_cmd(random_cmd());
  endtask

  // reads of the store as left by the clearing pass, in and out of range
  task automatic test_reset_state();
    send_cmd(make_cmd(KIND_READ, -1, -1, -1, 0));
    send_cmd(make_cmd(KIND_READ, -1, -1, -1, N_CELLS - 1));
    send_cmd(make_cmd(KIND_READ, -1, -1, -1, 2047));
  endtask

  // attribute and character at both ends of their range
  task automatic test_attribute_extremes();
    set_attr(8'h00);
    send_cmd(make_cmd(KIND_PUT, 8'hFF));
    send_cmd(make_cmd(KIND_READ, -1, -1, -1, 0));
    set_attr(8'hFF);
    send_cmd(make_cmd(KIND_PUT, 8'h00));
    send_cmd(make_cmd(KIND_READ, -1, -1, -1, 1));
  endtask

  // saturation, wrap, scroll, tab, backspace, return, clear
  task automatic test_cursor_and_controls();
    set_attr(8'h1E);
    send_cmd(make_cmd(KIND_SET, -1, 127, 31));
    send_cmd(make_cmd(KIND_PUT, "Z"));
    send_cmd(make_cmd(KIND_READ, -1, -1, -1, N_CELLS - N_COLS - 1));
    send_cmd(make_cmd(KIND_PUT, CH_BACKSPACE));
    send_cmd(make_cmd(KIND_PUT, CH_TAB));
    send_cmd(make_cmd(KIND_PUT, CH_BACKSPACE));
    send_cmd(make_cmd(KIND_PUT, "a"));
    send_cmd(make_cmd(KIND_PUT, CH_RETURN));
    send_cmd(make_cmd(KIND_SET, -1, 75, N_ROWS - 1));
    send_cmd(make_cmd(KIND_PUT, CH_TAB));
    send_cmd(make_cmd(KIND_PUT, CH_NEWLINE));
    send_cmd(make_cmd(KIND_SET, -1, 40, 10));
    send_cmd(make_cmd(KIND_PUT, CH_NEWLINE));
    send_cmd(make_cmd(KIND_READ, -1, -1, -1, N_CELLS));
    send_cmd(make_cmd(KIND_CLEAR));
    send_cmd(make_cmd(KIND_READ, -1, -1, -1, 0));
  endtask

  // random traffic under a range of attributes
  task automatic test_random_phases();
    logic [7:0] attrs [4];
    attrs = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
    foreach (attrs[p]) begin
      set_attr(attrs[p]);
      random_traffic(140);
    end
  endtask

  // both sides busy every cycle
  task automatic test_no_idle_stretch();
    no_idle = 1'b1;
    random_traffic(150);
    no_idle = 1'b0;
  endtask

  // receiver holds off while commands keep coming, so the input stalls
  task automatic test_output_hold_off();
    rx_hold_len = 400;
    random_traffic(60);
  endtask

  // sender pauses once to wait for every report before going on
  task automatic test_sender_pause();
    random_traffic(20);
    drain_reports();
    random_traffic(80);
  endtask

  // receiver: random ready, a steady stretch and one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_len > 0) begin
        hold_left   = rx_hold_len;
        rx_hold_len = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (no_idle) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 33);
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  // compare each result beat with the oldest report
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (reports_q.size() == 0) begin
        $error("result beat with no command pending: 0x%0h", out_data);
        fails++;
      end else begin
        report_seen = reports_q.pop_front();
        check_field("cell_value", report_seen.cell_value, out_data.cell_value);
        check_field("cursor_column", report_seen.cursor_column, out_data.cursor_column);
        check_field("cursor_row", report_seen.cursor_row, out_data.cursor_row);
        check_field("cursor_position", report_seen.cursor_position, out_data.cursor_position);
        check_field("scrolled", report_seen.scrolled, out_data.scrolled);
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // reset, test sequence and final verdict
  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    shadow_attr = RESET_ATTR;
    shadow_col  = 0;
    shadow_row  = 0;
    blank_screen();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_attribute_extremes();
    test_cursor_and_controls();
    test_random_phases();
    test_no_idle_stretch();
    test_output_hold_off();
    test_sender_pause();

    drain_reports();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tmcw_pkg.sv
design/tmcw_front.sv
design/tmcw_queue.sv
design/tmcw_back.sv
design/text_mode_console_writer.sv
design/tmcw_checker.sv
test/tb_text_mode_console_writer.sv
